// File: hdl/sifr_pkg.sv
// Shared types, constants and helpers of the stuffed information frame receiver.
package sifr_pkg;

    localparam int MAX_BYTES = 1024;
    localparam int CNT_W = $clog2(MAX_BYTES + 1);
    localparam int LEN_W = 11;
    localparam int MINLEN_W = 4;
    localparam int CMP_W = (CNT_W > MINLEN_W) ? CNT_W : MINLEN_W;
    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW = $clog2(FIFO_DEPTH);

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_ADDR_BYTE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH = 2'd1;

    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE = 8'h7D;
    localparam logic [7:0] ESC_FLAG = 8'h5E;
    localparam logic [7:0] ESC_ESC = 8'h5D;
    localparam logic [7:0] CTRL_ZERO = 8'h00;
    localparam logic [7:0] CTRL_ONE = 8'h40;

    localparam logic [7:0] ADDR_RESET = 8'd3;
    localparam logic [MINLEN_W-1:0] MINLEN_RESET = 4'd2;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_FLAG,
        PH_ADDR,
        PH_CTRL,
        PH_HDR,
        PH_DATA,
        PH_ESC
    } phase_t;

    typedef enum logic [2:0] {
        KIND_BYTE  = 3'd0,
        KIND_GOOD  = 3'd1,
        KIND_SHORT = 3'd2,
        KIND_BADESC = 3'd3,
        KIND_OVER  = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t            kind;
        logic [7:0]       data;
        logic             seq_bit;
        logic [LEN_W-1:0] length;
        logic             last;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    function automatic logic [LEN_W-1:0] sat_len(input logic [CNT_W-1:0] c);
        logic [LEN_W-1:0] r;
        r = LEN_W'(c);
        if (CNT_W > LEN_W && c > CNT_W'(LEN_MAX))
        begin
            r = LEN_MAX;
        end
        return r;
    endfunction

endpackage

// File: hdl/stuffed_info_frame_receiver.sv
// Top level of the stuffed information frame receiver.
//
// The s_axis channel takes one raw line byte per item. The receiver hunts for
// an opening flag, checks address, control and header check, then unstuffs
// the payload. Each payload byte leaves on m_axis as a kind 0 item; a closing
// flag after payload, a bad escape or an overflow leaves as one end item with tlast high.
// The cfg channel writes the address byte (index 0) and the minimum length
// (index 1); cfg_ready is always high. The user must make writes only while
// idle; the block does not enforce it. One byte is accepted every cycle while
// the result queue has room. A result passes through the queue and the output
// register: the state machine decides combinationally and writes the queue at
// the edge that accepts its byte, and the output register loads from the queue
// when it is empty or its item is taken on m_axis. When the receiver stalls
// m_axis, up to four results wait in the queue and the output register holds
// its item; s_axis_tready is low while the queue is full.
// Reset returns the block to hunting, clears the byte count and sequence bit,
// and loads the address 3 and minimum length 2.
module stuffed_info_frame_receiver
    import sifr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [7:0] rx_byte
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [23:0]          m_axis_tdata,   // [7:0] data, [8] seq_bit, [19:9] length
    output logic [2:0]           m_axis_tuser,   // [2:0] kind
    output logic                 m_axis_tlast
);

    push_t      push;
    item_t      head;
    item_t      out_item;
    fifo_stat_t stat;
    logic       pop;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !stat.full;

    sifr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_axis_tvalid && s_axis_tready),
        .in_byte   (s_axis_tdata),
        .push      (push)
    );

    sifr_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .stat  (stat)
    );

    sifr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .stat      (stat),
        .pop       (pop),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_item  (out_item)
    );

    assign m_axis_tdata = {4'd0, out_item.length, out_item.seq_bit, out_item.data};
    assign m_axis_tuser = out_item.kind;
    assign m_axis_tlast = out_item.last;

endmodule

// File: hdl/sifr_front.sv
// Front part: configuration registers, frame hunting and unstuffing state machine.
module sifr_front
    import sifr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    input  logic                 in_valid,
    input  logic [7:0]           in_byte,
    output push_t                push
);

    phase_t                phase_reg, phase_next;
    logic                  ctrl_seen_reg, ctrl_seen_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [7:0]            addr_reg;
    logic [MINLEN_W-1:0]   minlen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            ctrl_seen_reg <= 1'b0;
            count_reg     <= '0;
            addr_reg      <= ADDR_RESET;
            minlen_reg    <= MINLEN_RESET;
        end
        else
        begin
            if (in_valid)
            begin
                phase_reg     <= phase_next;
                ctrl_seen_reg <= ctrl_seen_next;
                count_reg     <= count_next;
            end
            if (cfg_valid && cfg_index == REG_ADDR_BYTE)
            begin
                addr_reg <= cfg_data;
            end
            if (cfg_valid && cfg_index == REG_MIN_LENGTH)
            begin
                minlen_reg <= cfg_data[MINLEN_W-1:0];
            end
        end
    end

    always_comb
    begin
        logic       take;
        logic [7:0] pay;
        logic [7:0] ctrl;
        take           = 1'b0;
        pay            = in_byte;
        ctrl           = ctrl_seen_reg ? CTRL_ONE : CTRL_ZERO;
        phase_next     = phase_reg;
        ctrl_seen_next = ctrl_seen_reg;
        count_next     = count_reg;
        push.valid        = 1'b0;
        push.item.kind    = KIND_BYTE;
        push.item.data    = 8'd0;
        push.item.seq_bit = ctrl_seen_reg;
        push.item.length  = sat_len(count_reg);
        push.item.last    = 1'b0;

        case (phase_reg)
            PH_HUNT:
            begin
                if (in_byte == FLAG_BYTE)
                begin
                    phase_next = PH_FLAG;
                end
            end
            PH_FLAG:
            begin
                if (in_byte == addr_reg)
                begin
                    phase_next = PH_ADDR;
                end
                else if (in_byte != FLAG_BYTE)
                begin
                    phase_next = PH_HUNT;
                end
            end
            PH_ADDR:
            begin
                if (in_byte == CTRL_ZERO || in_byte == CTRL_ONE)
                begin
                    ctrl_seen_next = (in_byte == CTRL_ONE);
                    phase_next     = PH_CTRL;
                end
                else
                begin
                    phase_next = (in_byte == FLAG_BYTE) ? PH_FLAG : PH_HUNT;
                end
            end
            PH_CTRL:
            begin
                if (in_byte == (addr_reg ^ ctrl))
                begin
                    phase_next = PH_HDR;
                    count_next = '0;
                end
                else
                begin
                    phase_next = (in_byte == FLAG_BYTE) ? PH_FLAG : PH_HUNT;
                end
            end
            PH_HDR:
            begin
                if (in_byte == FLAG_BYTE)
                begin
                    phase_next = PH_HUNT;
                    count_next = '0;
                end
                else if (in_byte == ESC_BYTE)
                begin
                    phase_next = PH_ESC;
                end
                else
                begin
                    take = 1'b1;
                end
            end
            PH_DATA:
            begin
                if (in_byte == FLAG_BYTE)
                begin
                    push.valid     = 1'b1;
                    push.item.kind = (CMP_W'(count_reg) < CMP_W'(minlen_reg)) ?
                                     KIND_SHORT : KIND_GOOD;
                    push.item.last = 1'b1;
                    phase_next     = PH_HUNT;
                    count_next     = '0;
                end
                else if (in_byte == ESC_BYTE)
                begin
                    phase_next = PH_ESC;
                end
                else
                begin
                    take = 1'b1;
                end
            end
            PH_ESC:
            begin
                if (in_byte == ESC_FLAG)
                begin
                    take = 1'b1;
                    pay  = FLAG_BYTE;
                end
                else if (in_byte == ESC_ESC)
                begin
                    take = 1'b1;
                    pay  = ESC_BYTE;
                end
                else
                begin
                    push.valid     = 1'b1;
                    push.item.kind = KIND_BADESC;
                    push.item.last = 1'b1;
                    phase_next     = PH_HUNT;
                    count_next     = '0;
                end
            end
            default:
            begin
                phase_next = PH_HUNT;
                count_next = '0;
            end
        endcase

        if (take)
        begin
            push.valid = 1'b1;
            if (count_reg >= CNT_W'(MAX_BYTES))
            begin
                push.item.kind = KIND_OVER;
                push.item.last = 1'b1;
                phase_next     = PH_HUNT;
                count_next     = '0;
            end
            else
            begin
                count_next       = count_reg + 1'b1;
                phase_next       = PH_DATA;
                push.item.data   = pay;
                push.item.length = sat_len(count_reg + 1'b1);
            end
        end

        if (!in_valid)
        begin
            push.valid = 1'b0;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HDR) |-> (count_reg == '0))
        else $error("Byte count is not clear right after the header.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= CNT_W'(MAX_BYTES)))
        else $error("Byte count passed the frame limit.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (push.valid && push.item.kind == KIND_BYTE) |=>
        (phase_reg == PH_DATA))
        else $error("Payload byte emitted without entering the data phase.");

endmodule

// File: hdl/sifr_fifo.sv
// Short result queue between the front part and the output stage.
module sifr_fifo
    import sifr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  push_t      push,
    input  logic       pop,
    output item_t      head,
    output fifo_stat_t stat
);

    item_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]   fill_reg, fill_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_AW'(push.valid);
        rd_ptr_next = rd_ptr_reg + FIFO_AW'(pop);
        fill_next   = fill_reg + (FIFO_AW + 1)'(push.valid) - (FIFO_AW + 1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            mem_reg[wr_ptr_reg] <= push.item;
        end
    end

    assign head       = mem_reg[rd_ptr_reg];
    assign stat.full  = (fill_reg == (FIFO_AW + 1)'(FIFO_DEPTH));
    assign stat.empty = (fill_reg == '0);

    assert property (@(posedge clk) disable iff (!rst_n)
        !(push.valid && stat.full))
        else $error("Item written into a full queue.");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && stat.empty))
        else $error("Item read from an empty queue.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg <= (FIFO_AW + 1)'(FIFO_DEPTH)))
        else $error("Queue fill count out of range.");

endmodule

// File: hdl/sifr_back.sv
// Back part: output register that presents result items to the downstream side.
module sifr_back
    import sifr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  item_t      head,
    input  fifo_stat_t stat,
    output logic       pop,
    input  logic       out_ready,
    output logic       out_valid,
    output item_t      out_item
);

    logic  valid_reg, valid_next;
    item_t item_reg, item_next;

    always_comb
    begin
        pop        = !stat.empty && (!valid_reg || out_ready);
        valid_next = valid_reg;
        item_next  = item_reg;
        if (pop)
        begin
            valid_next = 1'b1;
            item_next  = head;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && out_item.kind == KIND_BYTE) |-> !out_item.last)
        else $error("Payload item marked as the end of a frame.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && out_item.kind != KIND_BYTE) |-> (out_item.data == 8'd0))
        else $error("End item carries nonzero data.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!stat.empty && !valid_reg) |=> valid_reg)
        else $error("Output stage failed to load a waiting item.");

endmodule
